>>> src/vtc_pkg.sv
// Shared types and constants for the VFD text command generator.
// No dependencies.
`default_nettype none

package vtc_pkg;

  // Display width in character cells (1..16).
  localparam int unsigned ColumnsDefault = 16;
  // Entries in the job queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;
  // Most bytes in one job besides the run of clearing spaces.
  localparam int unsigned JobBytes = 4;

  typedef enum logic [3:0] {
    CmdPutChar    = 4'd0,
    CmdSetColumn  = 4'd1,
    CmdMove       = 4'd2,
    CmdCursorShow = 4'd3,
    CmdEntryDir   = 4'd4,
    CmdClear      = 4'd5,
    CmdHome       = 4'd6,
    CmdBrightness = 4'd7,
    CmdPower      = 4'd8
  } cmd_e;

  // Controller byte codes (low bits carry column or level).
  localparam logic [7:0] BytePointer   = 8'hE0;
  localparam logic [7:0] ByteCursorOn  = 8'h10;
  localparam logic [7:0] ByteCursorOff = 8'h80;
  localparam logic [7:0] ByteBright    = 8'h08;
  localparam logic [7:0] ByteDispOn    = 8'hF1;
  localparam logic [7:0] ByteDispOff   = 8'hF0;
  localparam logic [7:0] ByteSpace     = 8'h20;

  // One classified operation: optional run of spaces, then up to four bytes.
  typedef struct packed {
    logic                      spaces;
    logic [2:0]                count;
    logic [JobBytes-1:0][7:0]  bytes;
  } job_t;

endpackage

`default_nettype wire

>>> src/vfd_text_command_generator.sv
// Top level of the VFD text command generator: front, job queue, back.
// Depends on vtc_pkg, vtc_front, vtc_fifo, vtc_back.
`default_nettype none

// Converts text operations (put char, set column, move, cursor show, entry
// direction, clear, home, brightness, display power) into the byte stream of
// a single-line VFD controller. Both channels are valid/ready; one transfer
// on the input gives 0 to COLUMNS+3 output transfers, the final one flagged
// by last_o. The front classifies each operation in the cycle it is taken
// and updates the cursor column, cursor-shown and entry-direction state at
// once, so it can take a new operation every cycle while the job queue
// (QueueDepth entries) has room. The back plays out one byte per cycle while
// the output side takes them; an operation emits 1 to 4 bytes (COLUMNS+1 to
// COLUMNS+3 for clear), and operations that emit nothing push no job. Output
// throughput is set by the back's one byte per cycle sequencer.
// cfg_we_i/cfg_wdata_i write the cursor_hardware bit (reset 1); write it
// only while the block is idle.

module vfd_text_command_generator #(
  parameter int unsigned Columns    = vtc_pkg::ColumnsDefault,
  parameter int unsigned QueueDepth = vtc_pkg::QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] command_i,
  input  wire logic [7:0] data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      command_byte_o,
  output logic            last_o
);

  vtc_pkg::job_t push_job, pop_job;
  logic          push, full, pop, q_valid;

  vtc_front #(
    .Columns (Columns)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_i      (data_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_job_o     (push_job)
  );

  // decouples classification from byte playout
  vtc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  vtc_back #(
    .Columns (Columns)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_job_i        (pop_job),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_byte_o (command_byte_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

>>> src/vtc_fifo.sv
// Small job queue between the classifier front and the byte sequencer back.
// Depends on vtc_pkg (job_t).
`default_nettype none

module vtc_fifo #(
  parameter int unsigned Depth = vtc_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vtc_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output vtc_pkg::job_t      pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vtc_pkg::job_t        mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

>>> src/vtc_front.sv
// Front end: takes operations, tracks cursor state and builds byte jobs.
// Depends on vtc_pkg (cmd_e, job_t, byte codes).
`default_nettype none

module vtc_front #(
  parameter int unsigned Columns = vtc_pkg::ColumnsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [3:0]    command_i,
  input  wire logic [7:0]    data_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output vtc_pkg::job_t      q_job_o
);

  localparam logic [3:0] LastCol = 4'(Columns - 1);

  logic       hw_q;
  logic [3:0] col_q, col_d;
  logic       shown_q, shown_d;
  logic       dec_q, dec_d;
  logic       accept;

  vtc_pkg::job_t job;
  logic [2:0]    n;
  logic [3:0]    target;
  logic          go;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (job.count != '0);
  assign q_job_o    = job;

  always_comb begin
    job        = '0;
    n          = '0;
    col_d      = col_q;
    shown_d    = shown_q;
    dec_d      = dec_q;
    target     = '0;
    go         = 1'b0;
    unique case (command_i)
      vtc_pkg::CmdPutChar: begin
        job.bytes[n[1:0]] = data_i;
        n = n + 1'b1;
        if (shown_q) begin
          job.bytes[n[1:0]] = vtc_pkg::ByteCursorOff | {4'h0, col_q};
          n = n + 1'b1;
        end
        if (dec_q) begin
          col_d = (col_q == 4'd0) ? LastCol : col_q - 1'b1;
          job.bytes[n[1:0]] = vtc_pkg::BytePointer | {4'h0, col_d};
          n = n + 1'b1;
        end else begin
          col_d = (col_q == LastCol) ? 4'd0 : col_q + 1'b1;
        end
        if (hw_q && shown_q) begin
          job.bytes[n[1:0]] = vtc_pkg::ByteCursorOn | {4'h0, col_d};
          n = n + 1'b1;
        end
      end
      vtc_pkg::CmdSetColumn: begin
        go     = 1'b1;
        target = data_i[3:0];
      end
      vtc_pkg::CmdMove: begin
        go     = 1'b1;
        target = data_i[0] ? col_q + 1'b1 : col_q - 1'b1;
      end
      vtc_pkg::CmdCursorShow: begin
        if (hw_q) begin
          if (data_i[0] && !shown_q) begin
            shown_d = 1'b1;
            job.bytes[n[1:0]] = vtc_pkg::ByteCursorOn | {4'h0, col_q};
            n = n + 1'b1;
          end else if (!data_i[0] && shown_q) begin
            shown_d = 1'b0;
            job.bytes[n[1:0]] = vtc_pkg::ByteCursorOff | {4'h0, col_q};
            n = n + 1'b1;
          end
        end
      end
      vtc_pkg::CmdEntryDir: begin
        dec_d = data_i[0];
      end
      vtc_pkg::CmdClear: begin
        job.spaces = 1'b1;
        go         = 1'b1;
        dec_d      = 1'b0;
      end
      vtc_pkg::CmdHome: begin
        go    = 1'b1;
        dec_d = 1'b0;
      end
      vtc_pkg::CmdBrightness: begin
        job.bytes[n[1:0]] = vtc_pkg::ByteBright | {5'h00, data_i[2:0]};
        n = n + 1'b1;
      end
      vtc_pkg::CmdPower: begin
        job.bytes[n[1:0]] = data_i[0] ? vtc_pkg::ByteDispOn : vtc_pkg::ByteDispOff;
        n = n + 1'b1;
      end
      default: begin
        // unused codes: no bytes, no state change
      end
    endcase
    // shared column move: if the cursor is shown, cursor off at the old column and on at the target, then pointer
    if (go) begin
      if (hw_q && shown_q) begin
        job.bytes[n[1:0]] = vtc_pkg::ByteCursorOff | {4'h0, col_q};
        n = n + 1'b1;
        job.bytes[n[1:0]] = vtc_pkg::ByteCursorOn | {4'h0, target};
        n = n + 1'b1;
      end
      col_d = target;
      job.bytes[n[1:0]] = vtc_pkg::BytePointer | {4'h0, target};
      n = n + 1'b1;
    end
    job.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= 1'b1;
      col_q   <= '0;
      shown_q <= 1'b0;
      dec_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hw_q <= cfg_wdata_i;
      end
      if (accept) begin
        col_q   <= col_d;
        shown_q <= shown_d;
        dec_q   <= dec_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/vtc_back.sv
// Back end: plays one job out as a byte stream through an output register.
// Depends on vtc_pkg (job_t, byte codes).
`default_nettype none

module vtc_back #(
  parameter int unsigned Columns = vtc_pkg::ColumnsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire vtc_pkg::job_t q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         command_byte_o,
  output logic               last_o
);

  localparam int unsigned SpW = $clog2(Columns + 1);

  vtc_pkg::job_t cur_q;
  logic          cur_valid_q, cur_valid_d;
  logic [SpW-1:0] sp_left_q, sp_left_d;
  logic [1:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic          advance, is_last, load;
  logic [7:0]    next_byte;

  assign advance   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign next_byte = (sp_left_q != '0) ? vtc_pkg::ByteSpace : cur_q.bytes[idx_q];
  assign is_last   = (sp_left_q == '0) && ({1'b0, idx_q} == cur_q.count - 1'b1);
  assign load      = q_valid_i && (!cur_valid_q || (advance && is_last));
  assign q_pop_o   = load;

  assign out_valid_o    = out_valid_q;
  assign command_byte_o = out_byte_q;
  assign last_o         = out_last_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    sp_left_d   = sp_left_q;
    idx_d       = idx_q;
    if (advance) begin
      if (sp_left_q != '0) begin
        sp_left_d = sp_left_q - 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
      if (is_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      sp_left_d   = q_job_i.spaces ? SpW'(Columns) : '0;
      idx_d       = '0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sp_left_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      sp_left_q   <= sp_left_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_job_i;
    end
    if (advance) begin
      out_byte_q <= next_byte;
      out_last_q <= is_last;
    end
  end

endmodule

`default_nettype wire
